### rtl/wsp_pkg.sv
// Shared types and constants of the WAV sample to PCM16 converter.
`timescale 1ns / 1ps

package wsp_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IS_FLOAT  = 2'd0;
    localparam logic [1:0] CFG_WIDTH     = 2'd1;
    localparam logic [1:0] CFG_CHANNELS  = 2'd2;

    // Sample width codes (code three behaves as four bytes).
    localparam logic [1:0] WIDTH_TWO     = 2'd0;
    localparam logic [1:0] WIDTH_THREE   = 2'd1;

    // Float conversion constants: |x| = m * 2^-(SHIFT_BASE - exp).
    localparam logic [7:0] SHIFT_BASE    = 8'd150;
    // At this shift or above, |65535 * x| < 1 and the result is zero.
    localparam logic [7:0] SHIFT_ZERO    = 8'd41;
    localparam logic [7:0] EXP_ALL_ONES  = 8'hFF;

    localparam logic [15:0] PCM_MAX      = 16'h7FFF;
    localparam logic [15:0] PCM_MIN      = 16'h8000;
    localparam logic [17:0] POS_LIMIT    = 18'd32767;
    localparam logic [17:0] NEG_LIMIT    = 18'd32768;

    typedef struct packed {
        logic       is_float;
        logic [1:0] width_code;
    } wsp_fmt_t;

    // Bytes per sample for a width code.
    function automatic logic [2:0] sample_byte_count(input logic [1:0] code);
        logic [2:0] bps;
        case (code)
            WIDTH_TWO:   bps = 3'd2;
            WIDTH_THREE: bps = 3'd3;
            default:     bps = 3'd4;
        endcase
        return bps;
    endfunction

endpackage

### rtl/wsp_frame_asm.sv
// Frame assembler: gathers data bytes into frames and registers channel 0 words.
`timescale 1ns / 1ps

module wsp_frame_asm import wsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  wsp_fmt_t    fmt,
    input  logic        two_channels,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        chunk_end,
    output logic        frame_valid,
    input  logic        frame_ready,
    output logic [31:0] frame_word,
    output wsp_fmt_t    frame_fmt
);

    logic [2:0]  pos_reg;
    logic [31:0] word_reg;
    logic        fr_valid_reg;
    logic [31:0] fr_word_reg;
    wsp_fmt_t    fr_fmt_reg;

    logic [2:0]  bps;
    logic [3:0]  frame_len;
    logic        complete;
    logic [31:0] word_next;
    logic        in_fire;
    logic        fr_load;

    assign bps       = sample_byte_count(fmt.width_code);
    assign frame_len = two_channels ? {bps, 1'b0} : {1'b0, bps};
    assign complete  = ({1'b0, pos_reg} + 4'd1) >= frame_len;

    // Byte k of the channel 0 sample lands in bits 8k+7..8k.
    always_comb
    begin
        if (pos_reg == 3'd0)
        begin
            word_next = {24'd0, data_byte};
        end
        else if (pos_reg < bps)
        begin
            word_next = word_reg | ({24'd0, data_byte} << {pos_reg[1:0], 3'b000});
        end
        else
        begin
            word_next = word_reg;
        end
    end

    assign fr_load  = !fr_valid_reg || frame_ready;
    assign in_ready = fr_load;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 3'd0;
            word_reg     <= 32'd0;
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (complete || chunk_end)
                begin
                    pos_reg  <= 3'd0;
                    word_reg <= 32'd0;
                end
                else
                begin
                    pos_reg  <= pos_reg + 3'd1;
                    word_reg <= word_next;
                end
            end
            if (fr_load)
            begin
                fr_valid_reg <= in_fire && complete;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fr_load && in_fire && complete)
        begin
            fr_word_reg <= word_next;
            fr_fmt_reg  <= fmt;
        end
    end

    assign frame_valid = fr_valid_reg;
    assign frame_word  = fr_word_reg;
    assign frame_fmt   = fr_fmt_reg;

endmodule

### rtl/wsp_conv.sv
// Two-stage sample converter: integer selection and float32 to PCM16 scaling.
`timescale 1ns / 1ps

module wsp_conv import wsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] word,
    input  wsp_fmt_t    fmt,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] sample_value,
    output logic        clipped,
    output logic        bad_format
);

    // Stage 1 registers.
    logic        st1_valid_reg;
    logic        st1_direct_reg;
    logic [15:0] st1_sample_reg;
    logic        st1_clip_reg;
    logic        st1_bad_reg;
    logic [39:0] st1_v_reg;
    logic [5:0]  st1_sh_reg;
    logic        st1_neg_reg;

    // Output registers.
    logic        out_valid_reg;
    logic [15:0] out_sample_reg;
    logic        out_clip_reg;
    logic        out_bad_reg;

    logic        st1_ready;
    logic        out_load;

    // Stage 1 decode.
    logic        neg;
    logic [7:0]  ex;
    logic [22:0] fr;
    logic [23:0] m;
    logic [7:0]  ex_eff;
    logic [7:0]  sh8;
    logic [39:0] v_next;
    logic        direct_next;
    logic [15:0] sample_next;
    logic        clip_next;
    logic        bad_next;

    assign neg    = word[31];
    assign ex     = word[30:23];
    assign fr     = word[22:0];
    assign m      = (ex == 8'd0) ? {1'b0, fr} : {1'b1, fr};
    assign ex_eff = (ex == 8'd0) ? 8'd1 : ex;
    assign sh8    = SHIFT_BASE - ex_eff;
    // m * 65535 as a shift and a subtract.
    assign v_next = {m, 16'd0} - {16'd0, m};

    always_comb
    begin
        direct_next = 1'b1;
        sample_next = 16'd0;
        clip_next   = 1'b0;
        bad_next    = 1'b0;
        if (!fmt.is_float)
        begin
            case (fmt.width_code)
                WIDTH_TWO:   sample_next = word[15:0];
                WIDTH_THREE: sample_next = word[23:8];
                default:     sample_next = word[31:16];
            endcase
        end
        else if (!fmt.width_code[1])
        begin
            bad_next = 1'b1;
        end
        else if (ex == EXP_ALL_ONES && fr != 23'd0)
        begin
            // Not a number: zero, flagged.
            clip_next = 1'b1;
        end
        else if (ex[7])
        begin
            // Infinity or magnitude of two or more.
            clip_next   = 1'b1;
            sample_next = neg ? PCM_MIN : PCM_MAX;
        end
        else if (sh8 >= SHIFT_ZERO)
        begin
            sample_next = 16'd0;
        end
        else
        begin
            direct_next = 1'b0;
        end
    end

    // Stage 2: y = (s*v - 2^sh) / 2^(sh+1), truncated toward zero.
    logic [41:0] pow;
    logic [41:0] v_ext;
    logic        v_below;
    logic        res_neg;
    logic [41:0] mag;
    logic [41:0] shifted;
    logic [17:0] qm;
    logic [15:0] calc_sample;
    logic        calc_clip;

    assign pow     = 42'd1 << st1_sh_reg;
    assign v_ext   = {2'b00, st1_v_reg};
    assign v_below = v_ext < pow;
    assign res_neg = st1_neg_reg || v_below;

    always_comb
    begin
        if (st1_neg_reg)
        begin
            mag = v_ext + pow;
        end
        else if (!v_below)
        begin
            mag = v_ext - pow;
        end
        else
        begin
            mag = pow - v_ext;
        end
    end

    assign shifted = mag >> ({1'b0, st1_sh_reg} + 7'd1);
    assign qm      = shifted[17:0];

    always_comb
    begin
        calc_clip = 1'b0;
        if (!res_neg && qm > POS_LIMIT)
        begin
            calc_clip   = 1'b1;
            calc_sample = PCM_MAX;
        end
        else if (res_neg && qm > NEG_LIMIT)
        begin
            calc_clip   = 1'b1;
            calc_sample = PCM_MIN;
        end
        else if (res_neg)
        begin
            calc_sample = 16'(~qm + 18'd1);
        end
        else
        begin
            calc_sample = qm[15:0];
        end
    end

    assign out_load  = !out_valid_reg || out_ready;
    assign st1_ready = !st1_valid_reg || out_load;
    assign in_ready  = st1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (st1_ready)
            begin
                st1_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= st1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st1_ready && in_valid)
        begin
            st1_direct_reg <= direct_next;
            st1_sample_reg <= sample_next;
            st1_clip_reg   <= clip_next;
            st1_bad_reg    <= bad_next;
            st1_v_reg      <= v_next;
            st1_sh_reg     <= sh8[5:0];
            st1_neg_reg    <= neg;
        end
        if (out_load && st1_valid_reg)
        begin
            out_sample_reg <= st1_direct_reg ? st1_sample_reg : calc_sample;
            out_clip_reg   <= st1_direct_reg ? st1_clip_reg : calc_clip;
            out_bad_reg    <= st1_bad_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = out_sample_reg;
    assign clipped      = out_clip_reg;
    assign bad_format   = out_bad_reg;

endmodule

### rtl/wav_sample_to_pcm16_converter.sv
// Top level of the WAV sample to PCM16 converter: configuration and pipeline.
`timescale 1ns / 1ps

// Channel   | Direction | Carries
// s_axis    | in        | one WAV data byte per item, tlast marks the end of a chunk
// m_axis    | out       | one signed 16-bit sample of channel 0 per complete frame
// cfg       | in        | register writes: float select, sample width, stereo
//
// An item is taken every cycle the input side is ready. Each complete frame goes
// through three registers in order (frame word, float product, result) before its
// sample appears. The handshake ready signals are chained back from the result
// register, so bubbles are filled and the input only stalls when every stage
// holds an item that the output side has not taken.
// Reset clears the frame position, the configuration and all valid bits.
//
// Bytes of channel 1 are counted but dropped. A chunk end that leaves a frame
// incomplete drops it without a result; the next byte starts a new frame.

module wav_sample_to_pcm16_converter import wsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // chunk_end

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_value
    output logic [1:0]  m_axis_tuser,   // [0] clipped, [1] bad_format

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_data
);

    logic       is_float_reg;
    logic [1:0] width_code_reg;
    logic       two_channels_reg;

    wsp_fmt_t    fmt;
    logic        frame_valid;
    logic        frame_ready;
    logic [31:0] frame_word;
    wsp_fmt_t    frame_fmt;
    logic        clipped;
    logic        bad_format;

    // Configuration registers; writes to an unused index are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_float_reg     <= 1'b0;
            width_code_reg   <= 2'd0;
            two_channels_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IS_FLOAT: is_float_reg     <= cfg_data[0];
                CFG_WIDTH:    width_code_reg   <= cfg_data;
                CFG_CHANNELS: two_channels_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign fmt.is_float   = is_float_reg;
    assign fmt.width_code = width_code_reg;

    wsp_frame_asm u_frame_asm (
        .clk          (clk),
        .rst_n        (rst_n),
        .fmt          (fmt),
        .two_channels (two_channels_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .data_byte    (s_axis_tdata),
        .chunk_end    (s_axis_tlast),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame_word   (frame_word),
        .frame_fmt    (frame_fmt)
    );

    wsp_conv u_conv (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (frame_valid),
        .in_ready     (frame_ready),
        .word         (frame_word),
        .fmt          (frame_fmt),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .sample_value (m_axis_tdata),
        .clipped      (clipped),
        .bad_format   (bad_format)
    );

    assign m_axis_tuser = {bad_format, clipped};

endmodule
